>>> design/odo_pkg.sv
// shared types, register indexes and constants of the odometry block
package odo_pkg;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MHEAD,
		ST_HADD,
		ST_CINIT,
		ST_ROT,
		ST_P0,
		ST_P1,
		ST_P2,
		ST_P3,
		ST_P4,
		ST_P5,
		ST_OUT
	} odo_state_t;

	// datapath operations issued by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_MHEAD,
		OP_HADD,
		OP_CINIT,
		OP_ROT,
		OP_P0,
		OP_P1,
		OP_P2,
		OP_P3,
		OP_P4,
		OP_P5,
		OP_OUT
	} dp_op_t;

	// controller to datapath command
	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	localparam int CFG_IDX_W = 4;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_TRAVEL_GAIN = cfg_idx_t'(0);
	localparam cfg_idx_t REG_TURN_GAIN   = cfg_idx_t'(1);

	localparam logic [31:0] TRAVEL_GAIN_RST = 32'd12266386;
	localparam logic [31:0] TURN_GAIN_RST   = 32'd6507526;

	// gain-compensated start vector, q2.30
	localparam logic signed [32:0] CORDIC_K = 33'sd652032874;
	// quarter turn in binary-angle units
	localparam logic signed [31:0] QUARTER  = 32'sd1073741824;

	localparam int ATAN_N = 30;
	// arctangent of 2^-i in binary-angle units
	localparam logic [29:0] ATAN_TAB [ATAN_N] = '{
		30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
		30'd21354465,  30'd10679838,  30'd5340245,   30'd2670163,  30'd1335087,
		30'd667544,    30'd333772,    30'd166886,    30'd83443,    30'd41722,
		30'd20861,     30'd10430,     30'd5215,      30'd2608,     30'd1304,
		30'd652,       30'd326,       30'd163,       30'd81,       30'd41,
		30'd20,        30'd10,        30'd5,         30'd3,        30'd1
	};

endpackage

>>> design/odo_rot.sv
// iterative rotation-mode cordic, one micro-rotation per cycle while step_en is high
module odo_rot #(
	parameter int STEP_W = 4
) (
	input  logic                     clk,
	input  logic                     init,
	input  logic                     step_en,
	input  logic [STEP_W-1:0]        step,
	input  logic signed [31:0]       z0,
	output logic signed [32:0]       x,
	output logic signed [32:0]       y
);
	import odo_pkg::*;

	logic signed [32:0] x_q;
	logic signed [32:0] y_q;
	logic signed [32:0] z_q;
	logic signed [32:0] xs;
	logic signed [32:0] ys;
	logic signed [32:0] atan_v;

	assign xs     = x_q >>> step;
	assign ys     = y_q >>> step;
	assign atan_v = signed'(33'(ATAN_TAB[5'(step)]));

	always_ff @(posedge clk) begin
		if (init) begin
			x_q <= CORDIC_K;
			y_q <= '0;
			z_q <= 33'(z0);
		end else if (step_en) begin
			if (!z_q[32]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - atan_v;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + atan_v;
			end
		end
	end

	assign x = x_q;
	assign y = y_q;

endmodule

>>> design/odo_ctrl.sv
// controller state machine sequencing one odometry update
module odo_ctrl #(
	parameter int STEPS  = 16,
	parameter int STEP_W = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output odo_pkg::dp_cmd_t      cmd,
	output logic [STEP_W-1:0]     step
);
	import odo_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	odo_state_t        state_q, state_d;
	logic [STEP_W-1:0] cnt_q, cnt_d;
	logic              out_valid_q, out_valid_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		cmd.op      = OP_NONE;
		in_ready    = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_MHEAD;
				end
			end
			ST_MHEAD: begin
				cmd.op  = OP_MHEAD;
				state_d = ST_HADD;
			end
			ST_HADD: begin
				cmd.op  = OP_HADD;
				state_d = ST_CINIT;
			end
			ST_CINIT: begin
				cmd.op  = OP_CINIT;
				cnt_d   = '0;
				state_d = ST_ROT;
			end
			ST_ROT: begin
				cmd.op = OP_ROT;
				if (cnt_q == LAST_STEP) begin
					state_d = ST_P0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_P0: begin
				cmd.op  = OP_P0;
				state_d = ST_P1;
			end
			ST_P1: begin
				cmd.op  = OP_P1;
				state_d = ST_P2;
			end
			ST_P2: begin
				cmd.op  = OP_P2;
				state_d = ST_P3;
			end
			ST_P3: begin
				cmd.op  = OP_P3;
				state_d = ST_P4;
			end
			ST_P4: begin
				cmd.op  = OP_P4;
				state_d = ST_P5;
			end
			ST_P5: begin
				cmd.op  = OP_P5;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				// wait for the output register to free up
				if (!out_valid_q || out_ready) begin
					cmd.op      = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign step      = cnt_q;

endmodule

>>> design/odo_dp.sv
// odometry datapath: deltas, shared multiplier, accumulators, cordics, output register
module odo_dp #(
	parameter int DELTA_BITS   = 16,
	parameter int STEP_W       = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  odo_pkg::dp_cmd_t        cmd,
	input  logic [STEP_W-1:0]       step,
	input  logic                    cfg_we,
	input  odo_pkg::cfg_idx_t       cfg_index,
	input  logic [31:0]             cfg_data,
	input  logic signed [31:0]      count_left,
	input  logic signed [31:0]      count_right,
	output logic signed [31:0]      pos_x,
	output logic signed [31:0]      pos_y,
	output logic signed [31:0]      heading,
	output logic signed [15:0]      quat_w,
	output logic signed [15:0]      quat_z
);
	import odo_pkg::*;

	localparam int     SUM_W = DELTA_BITS + 1;
	localparam longint DHI   = (longint'(1) <<< (DELTA_BITS - 1)) - 1;
	localparam longint DLO   = -(longint'(1) <<< (DELTA_BITS - 1));

	function automatic logic signed [DELTA_BITS-1:0] sat_delta(
		input logic [31:0] cur,
		input logic [31:0] prev
	);
		logic signed [31:0] d;
		d = signed'(cur - prev);
		if (longint'(d) > DHI) return DELTA_BITS'(DHI);
		if (longint'(d) < DLO) return DELTA_BITS'(DLO);
		return DELTA_BITS'(d);
	endfunction

	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] r;
		r = (34'(v) + 34'sd16384) >>> 15;
		if (r > 34'sd32767) return 16'sh7fff;
		if (r < -34'sd32768) return 16'sh8000;
		return r[15:0];
	endfunction

	// state and configuration
	logic [31:0] travel_gain_q;
	logic [31:0] turn_gain_q;
	logic [31:0] prev_left_q;
	logic [31:0] prev_right_q;
	logic [31:0] heading_q;
	logic [47:0] x_acc_q;
	logic [47:0] y_acc_q;

	// working registers
	logic [SUM_W-1:0] sum_abs_q;
	logic             sum_neg_q;
	logic [31:0]      diff_q;
	logic [63:0]      m_q;
	logic [63:0]      p_q;
	logic [33:0]      t_q;
	logic [47:0]      mag_q;
	logic             fold_q;

	logic signed [31:0] out_x_q, out_y_q, out_h_q;
	logic signed [15:0] out_w_q, out_z_q;

	// delta stage
	logic signed [DELTA_BITS-1:0] dl, dr;
	logic signed [SUM_W-1:0]      sum_w;
	logic signed [32:0]           diff_w;

	assign dl     = sat_delta(count_left, prev_left_q);
	assign dr     = sat_delta(count_right, prev_right_q);
	assign sum_w  = SUM_W'(dl) + SUM_W'(dr);
	assign diff_w = 33'(dl) - 33'(dr);

	// cordic angles
	logic signed [31:0] h;
	logic               fold;
	logic signed [31:0] z_full;
	logic signed [31:0] z_half;

	assign h      = signed'(heading_q);
	assign fold   = (h > QUARTER) || (h < -QUARTER);
	assign z_full = fold ? signed'({~h[31], h[30:0]}) : h;
	assign z_half = h >>> 1;

	logic signed [32:0] fc, fs, hc, hs;
	logic               rot_init, rot_step;

	assign rot_init = (cmd.op == OP_CINIT);
	assign rot_step = (cmd.op == OP_ROT);

	odo_rot #(.STEP_W(STEP_W)) u_rot_full (
		.clk     (clk),
		.init    (rot_init),
		.step_en (rot_step),
		.step    (step),
		.z0      (z_full),
		.x       (fc),
		.y       (fs)
	);

	odo_rot #(.STEP_W(STEP_W)) u_rot_half (
		.clk     (clk),
		.init    (rot_init),
		.step_en (rot_step),
		.step    (step),
		.z0      (z_half),
		.x       (hc),
		.y       (hs)
	);

	// magnitude and sign of the full-angle cos and sin (fold negates)
	logic [32:0] fc_abs_w, fs_abs_w;
	logic [31:0] c_abs, s_abs;
	logic        c_neg, s_neg;

	assign fc_abs_w = fc[32] ? 33'(-fc) : 33'(fc);
	assign fs_abs_w = fs[32] ? 33'(-fs) : 33'(fs);
	assign c_abs    = fc_abs_w[31:0];
	assign s_abs    = fs_abs_w[31:0];
	assign c_neg    = fold_q ? (fc > 33'sd0) : fc[32];
	assign s_neg    = fold_q ? (fs > 33'sd0) : fs[32];

	// shared multiplier
	logic [32:0] mul_a;
	logic [31:0] mul_b;
	logic [64:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.op)
			OP_MHEAD: begin
				mul_a = 33'(diff_q);
				mul_b = turn_gain_q;
			end
			OP_HADD: begin
				mul_a = 33'(sum_abs_q);
				mul_b = travel_gain_q;
			end
			OP_P0: begin
				mul_a = 33'(m_q[31:0]);
				mul_b = c_abs;
			end
			OP_P1: begin
				mul_a = 33'(m_q[63:32]);
				mul_b = c_abs;
			end
			OP_P2: begin
				mul_a = 33'(m_q[31:0]);
				mul_b = s_abs;
			end
			OP_P3: begin
				mul_a = 33'(m_q[63:32]);
				mul_b = s_abs;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod = 65'(mul_a) * 65'(mul_b);

	logic [47:0] mag_w;
	assign mag_w = 48'(t_q) + {p_q[45:0], 2'b00};

	// configuration and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			travel_gain_q <= TRAVEL_GAIN_RST;
			turn_gain_q   <= TURN_GAIN_RST;
			prev_left_q   <= '0;
			prev_right_q  <= '0;
			heading_q     <= '0;
			x_acc_q       <= '0;
			y_acc_q       <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TRAVEL_GAIN: travel_gain_q <= cfg_data;
					REG_TURN_GAIN:   turn_gain_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			unique case (cmd.op)
				OP_LOAD: begin
					prev_left_q  <= count_left;
					prev_right_q <= count_right;
				end
				OP_HADD: heading_q <= heading_q + p_q[31:0];
				OP_P3: begin
					if (sum_neg_q != c_neg) x_acc_q <= x_acc_q - mag_q;
					else x_acc_q <= x_acc_q + mag_q;
				end
				OP_P5: begin
					if (sum_neg_q != s_neg) y_acc_q <= y_acc_q - mag_q;
					else y_acc_q <= y_acc_q + mag_q;
				end
				default: begin
				end
			endcase
		end
	end

	// working and output registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				sum_abs_q <= sum_w[SUM_W-1] ? SUM_W'(-sum_w) : SUM_W'(sum_w);
				sum_neg_q <= sum_w[SUM_W-1];
				diff_q    <= diff_w[31:0];
			end
			OP_MHEAD: p_q <= prod[63:0];
			OP_HADD:  m_q <= prod[63:0];
			OP_CINIT: fold_q <= fold;
			OP_P0:    p_q <= prod[63:0];
			OP_P1: begin
				t_q <= p_q[63:30];
				p_q <= prod[63:0];
			end
			OP_P2: begin
				mag_q <= mag_w;
				p_q   <= prod[63:0];
			end
			OP_P3: begin
				t_q <= p_q[63:30];
				p_q <= prod[63:0];
			end
			OP_P4: mag_q <= mag_w;
			OP_OUT: begin
				out_x_q <= signed'(x_acc_q[47:16]);
				out_y_q <= signed'(y_acc_q[47:16]);
				out_h_q <= signed'(heading_q);
				out_w_q <= to_q15(hc);
				out_z_q <= to_q15(hs);
			end
			default: begin
			end
		endcase
	end

	assign pos_x   = out_x_q;
	assign pos_y   = out_y_q;
	assign heading = out_h_q;
	assign quat_w  = out_w_q;
	assign quat_z  = out_z_q;

endmodule

>>> design/differential_drive_odometry.sv
// top level of the differential-drive dead-reckoning odometry block
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid, in_ready, count_left, count_right    | request in
//  out     | out_valid, out_ready, pos_x, pos_y, heading,   | request out
//          | quat_w, quat_z                                 |
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data      | write in
//
// a new request is taken only once the previous one is through; the pace is set by
// the iterative cordic, one micro-rotation per cycle, and the shared 33x32 multiplier
// that takes six passes for the heading, travel and position products.
// reset clears the heading, the position accumulators and the last counts and
// loads the default gains; no clearing pass is needed.
// the output register holds a finished result while the next request is taken;
// a stalled output only holds back the final write of the following result.
module differential_drive_odometry #(
	parameter int CORDIC_STEPS = 16,
	parameter int DELTA_BITS   = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// input requests
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        count_left,
	input  logic signed [31:0]        count_right,
	// results
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        pos_x,
	output logic signed [31:0]        pos_y,
	output logic signed [31:0]        heading,
	output logic signed [15:0]        quat_w,
	output logic signed [15:0]        quat_z,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  odo_pkg::cfg_idx_t         cfg_index,
	input  logic [31:0]               cfg_data
);
	import odo_pkg::*;

	// step counter width for the cordic iterations
	localparam int STEP_W = $clog2(CORDIC_STEPS);

	dp_cmd_t           cmd;
	logic [STEP_W-1:0] step;
	logic              cfg_we;

	// the user is to write gains only while idle; the block does not enforce it, so writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	// sequencer: load, heading update, cordic loop, position products, result
	odo_ctrl #(.STEPS(CORDIC_STEPS), .STEP_W(STEP_W)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.step      (step)
	);

	// arithmetic, state accumulators and output register
	odo_dp #(
		.DELTA_BITS   (DELTA_BITS),
		.STEP_W       (STEP_W)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.step        (step),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.count_left  (count_left),
		.count_right (count_right),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.heading     (heading),
		.quat_w      (quat_w),
		.quat_z      (quat_z)
	);

endmodule

>>> tb/sv/tb_differential_drive_odometry.sv
`timescale 1ns / 100ps
// self-checking testbench of the differential-drive odometry block
module tb_differential_drive_odometry;
	import odo_pkg::*;

	localparam int STEPS = 16;
	localparam int DBITS = 16;
	// percent of cycles in which either side sits idle
	localparam int IDLE_PCT = 37;
	localparam int STALL_CYCLES = 400;
	localparam longint CYCLE_LIMIT = 400000;
	localparam int MAX_PRINTED = 100;
	// an index that maps to no register, writes to it must change nothing
	localparam cfg_idx_t REG_SPARE = cfg_idx_t'(11);
	localparam longint QUARTER_TURN = 64'sd1073741824;
	// gain-compensated start vector of the rotation, q2.30
	localparam longint ROT_START = 64'sd652032874;
	// arctangent of 2^-i as a binary angle
	localparam longint ATAN_BA [30] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
		41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
		10, 5, 3, 1
	};

	typedef struct {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] hd;
		logic [15:0] w;
		logic [15:0] z;
	} pose_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic signed [31:0] count_left;
	logic signed [31:0] count_right;
	logic out_valid;
	logic out_ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] heading;
	logic signed [15:0] quat_w;
	logic signed [15:0] quat_z;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	logic [31:0] cfg_data;

	differential_drive_odometry #(
		.CORDIC_STEPS(STEPS),
		.DELTA_BITS(DBITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.count_left(count_left),
		.count_right(count_right),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.heading(heading),
		.quat_w(quat_w),
		.quat_z(quat_z),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// mirror of the block state, advanced once per accepted request
	logic [31:0] gain_travel;
	logic [31:0] gain_turn;
	logic [31:0] last_l;
	logic [31:0] last_r;
	logic [31:0] hd_acc;
	logic [47:0] x_acc;
	logic [47:0] y_acc;

	// poses still owed by the block, oldest first
	pose_t pending_poses[$];

	// counts last offered, so directed moves can be given as wheel deltas
	logic [31:0] stim_l;
	logic [31:0] stim_r;

	int errors;
	longint cycles;
	bit no_gaps;
	int hold_seq;
	int hold_seen;
	int stall_left;

	always #1 clk = ~clk;

	// wrapped count difference, clamped to the signed delta range
	function automatic longint clamp_delta(logic [31:0] cur, logic [31:0] prev);
		longint d;
		longint hi;
		longint lo;
		d = longint'($signed(cur - prev));
		hi = (longint'(1) << (DBITS - 1)) - 1;
		lo = -(longint'(1) << (DBITS - 1));
		if (d > hi)
			return hi;
		if (d < lo)
			return lo;
		return d;
	endfunction

	// rotation-mode cordic, angle within plus or minus a quarter turn
	function automatic void cordic_rot(input longint ang, output longint c, output longint s);
		longint x;
		longint y;
		longint z;
		longint xs;
		longint ys;
		x = ROT_START;
		y = 0;
		z = ang;
		for (int i = 0; i < STEPS && i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys;
				y = y + xs;
				z = z - ATAN_BA[i];
			end else begin
				x = x + ys;
				y = y - xs;
				z = z + ATAN_BA[i];
			end
		end
		c = x;
		s = y;
	endfunction

	// one axis of the position update, magnitude rounded toward zero
	function automatic logic [47:0] travel_step(logic [47:0] acc, longint sum, longint trig);
		longint unsigned m;
		longint unsigned c;
		longint unsigned mag;
		m = (sum < 0) ? -sum : sum;
		m = m * {32'd0, gain_travel};
		c = (trig < 0) ? -trig : trig;
		mag = (m >> 32) * c * 4 + (((m & 64'hFFFF_FFFF) * c) >> 30);
		if ((sum < 0) != (trig < 0))
			return acc - 48'(mag);
		return acc + 48'(mag);
	endfunction

	// q2.30 to q1.15, round half up, saturate
	function automatic logic [15:0] to_q15(longint v);
		longint r;
		r = (v + 16384) >>> 15;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return 16'(r);
	endfunction

	function automatic pose_t advance_pose(logic [31:0] cl, logic [31:0] cr);
		longint dl;
		longint dr;
		longint sum;
		longint h;
		longint c;
		longint s;
		longint hc;
		longint hs;
		logic [31:0] diff;
		pose_t p;
		dl = clamp_delta(cl, last_l);
		dr = clamp_delta(cr, last_r);
		sum = dl + dr;
		diff = 32'(dl - dr);
		last_l = cl;
		last_r = cr;
		// heading first, then travel along the new heading
		hd_acc = hd_acc + diff * gain_turn;
		h = longint'($signed(hd_acc));
		if (h > QUARTER_TURN || h < -QUARTER_TURN) begin
			// fold into the right half plane and flip the result
			cordic_rot(longint'($signed(hd_acc + 32'h8000_0000)), c, s);
			c = -c;
			s = -s;
		end else begin
			cordic_rot(h, c, s);
		end
		x_acc = travel_step(x_acc, sum, c);
		y_acc = travel_step(y_acc, sum, s);
		// half angle for the quaternion, floor of the signed heading
		cordic_rot(h >>> 1, hc, hs);
		p.x = x_acc[47:16];
		p.y = y_acc[47:16];
		p.hd = hd_acc;
		p.w = to_q15(hc);
		p.z = to_q15(hs);
		return p;
	endfunction

	task automatic report_mismatch(string what, longint want, longint got);
		errors++;
		if (errors <= MAX_PRINTED)
			$display("mismatch on %s: expected %0d, got %0d, cycle %0d", what, want, got, cycles);
	endtask

	// offer one request, with random idle cycles ahead of it; valid stays up on return
	task automatic send_counts(logic [31:0] l, logic [31:0] r);
		while (!no_gaps && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		count_left <= l;
		count_right <= r;
		do @(posedge clk); while (!in_ready);
		pending_poses.push_back(advance_pose(l, r));
		stim_l = l;
		stim_r = r;
	endtask

	task automatic step_by(longint dl, longint dr);
		send_counts(stim_l + 32'(dl), stim_r + 32'(dr));
	endtask

	// stop offering and wait until every owed pose has come back
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_poses.size() != 0);
	endtask

	// writes both gains, then optionally the unused index; block must be idle
	task automatic write_regs(logic [31:0] travel, logic [31:0] turn, bit spare);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TRAVEL_GAIN;
		cfg_data <= travel;
		do @(posedge clk); while (!cfg_ready);
		gain_travel = travel;
		cfg_index <= REG_TURN_GAIN;
		cfg_data <= turn;
		do @(posedge clk); while (!cfg_ready);
		gain_turn = turn;
		if (spare) begin
			cfg_index <= REG_SPARE;
			cfg_data <= $urandom();
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
	endtask

	// a small random move, the common case of a rolling robot
	task automatic small_move();
		longint base;
		longint turn;
		base = longint'($urandom_range(3000)) - 1500;
		turn = longint'($urandom_range(600)) - 300;
		step_by(base + turn, base - turn);
	endtask

	// default gains: straight runs, spins, saturation and count wrap
	task automatic test_default_moves();
		step_by(0, 0);
		step_by(100, 100);
		step_by(-100, -100);
		step_by(500, -500);
		step_by(-500, 500);
		step_by(32767, 32767);
		step_by(-32768, -32768);
		// jumps beyond the delta range clamp at its ends
		step_by(100000, -100000);
		step_by(-70000, 70000);
		send_counts(32'h7FFF_FFF0, 32'h7FFF_FFF0);
		// crossing the count wrap is a small forward move
		send_counts(32'h8000_0010, 32'h8000_0010);
		send_counts(32'h7FFF_FFFF, 32'h8000_0000);
		send_counts(32'h8000_0000, 32'h7FFF_FFFF);
		send_counts(32'h0000_0000, 32'hFFFF_FFFF);
		send_counts(32'hFFFF_FFFF, 32'h0000_0000);
	endtask

	// gain extremes, the quarter-turn fold edges, heading and position wrap
	task automatic test_gain_extremes();
		drain();
		// land the heading exactly on a quarter turn
		write_regs(32'hFFFF_FFFF, 32'h4000_0000 - hd_acc, 1'b1);
		step_by(1, 0);
		drain();
		write_regs(32'hFFFF_FFFF, 32'h4000_0000, 1'b0);
		step_by(1, 0);
		step_by(0, 1);
		step_by(0, 2);
		// full travel gain wraps the position accumulators
		step_by(32767, 32767);
		step_by(32767, 32767);
		step_by(-32768, -32768);
		drain();
		write_regs(32'h0000_0000, 32'h0000_0000, 1'b1);
		step_by(1000, -2000);
		step_by(-32768, 32767);
		drain();
		// largest turn gain with the widest difference wraps the heading
		write_regs(32'h0000_0001, 32'hFFFF_FFFF, 1'b0);
		step_by(32767, -32768);
		step_by(-32768, 32767);
		step_by(1234, -77);
		drain();
		write_regs(TRAVEL_GAIN_RST, TURN_GAIN_RST, 1'b0);
	endtask

	// bulk traffic over several gain settings, mostly plausible motion
	task automatic test_random_traffic();
		int kind;
		for (int phase = 0; phase < 4; phase++) begin
			drain();
			case (phase)
				0: begin
					write_regs(TRAVEL_GAIN_RST, TURN_GAIN_RST, 1'b0);
				end
				1: begin
					write_regs($urandom(), $urandom(), 1'b1);
				end
				2: begin
					write_regs($urandom_range(1 << 24), $urandom_range(1 << 26), 1'b0);
				end
				default: begin
					write_regs(32'hFFFF_FFFF, $urandom(), 1'b0);
				end
			endcase
			// one phase runs back to back on both sides
			no_gaps = (phase == 2);
			repeat (100) begin
				kind = $urandom_range(99);
				if (kind < 70) begin
					small_move();
				end else if (kind < 85) begin
					step_by(longint'($urandom_range(160000)) - 80000,
						longint'($urandom_range(160000)) - 80000);
				end else if (kind < 93) begin
					send_counts($urandom(), $urandom());
				end else begin
					send_counts(stim_l, stim_r);
				end
			end
		end
		no_gaps = 1'b0;
	endtask

	// output held off for a long stretch while requests keep coming
	task automatic test_output_stall();
		drain();
		no_gaps = 1'b1;
		hold_seq++;
		repeat (12) small_move();
		no_gaps = 1'b0;
	endtask

	// sender stops mid-stream until all owed poses are back
	task automatic test_sender_pause();
		repeat (3) begin
			repeat (5) small_move();
			drain();
		end
	endtask

	// receiver: random ready, or a counted hold-off when one is requested
	always @(posedge clk) begin
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			stall_left = STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_gaps || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// compare each accepted pose with the oldest one owed
	always @(posedge clk) begin : pose_check
		pose_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_poses.size() == 0) begin
				report_mismatch("unexpected result", 0, longint'(pos_x));
			end else begin
				want = pending_poses.pop_front();
				if (pos_x !== want.x)
					report_mismatch("pos_x", longint'($signed(want.x)), longint'(pos_x));
				if (pos_y !== want.y)
					report_mismatch("pos_y", longint'($signed(want.y)), longint'(pos_y));
				if (heading !== want.hd)
					report_mismatch("heading", longint'($signed(want.hd)), longint'(heading));
				if (quat_w !== want.w)
					report_mismatch("quat_w", longint'($signed(want.w)), longint'(quat_w));
				if (quat_z !== want.z)
					report_mismatch("quat_z", longint'($signed(want.z)), longint'(quat_z));
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[differential_drive_odometry] ERROR");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		count_left = '0;
		count_right = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_TRAVEL_GAIN;
		cfg_data = '0;
		errors = 0;
		cycles = 0;
		no_gaps = 1'b0;
		hold_seq = 0;
		hold_seen = 0;
		stall_left = 0;
		stim_l = '0;
		stim_r = '0;
		// state right after reset
		gain_travel = TRAVEL_GAIN_RST;
		gain_turn = TURN_GAIN_RST;
		last_l = '0;
		last_r = '0;
		hd_acc = '0;
		x_acc = '0;
		y_acc = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		test_default_moves();
		test_gain_extremes();
		test_random_traffic();
		test_output_stall();
		test_sender_pause();

		drain();
		// a few more cycles to catch any stray result
		repeat (40) @(posedge clk);
		if (errors == 0) begin
			$display("[differential_drive_odometry] OK");
		end else begin
			$display("[differential_drive_odometry] ERROR");
		end
		$finish;
	end

endmodule

>>> differential_drive_odometry.f
design/odo_pkg.sv
design/odo_rot.sv
design/odo_ctrl.sv
design/odo_dp.sv
design/differential_drive_odometry.sv
tb/sv/tb_differential_drive_odometry.sv
